FILE: sv/smm_pkg.sv
// Shared constants, codes and types for the square matrix multiply core.
// No dependencies; compiled first.
`default_nettype none

package smm_pkg;

	// matrix geometry
	localparam int MAX_SIZE = 16;
	localparam int IDX_W    = 4;
	localparam int ADDR_W   = 2 * IDX_W;
	localparam int SIZE_W   = 5;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
	localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SIZE);

	// data widths
	localparam int ELEM_W = 16;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int ACC_W  = 40;

	// request action codes
	localparam int ACT_W = 2;
	localparam logic [ACT_W-1:0] ACT_LOAD_A = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD_B = 2'd1;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_DONE
	} state_t;

	// controls from the sequencer to the MAC, aligned with the read issue
	typedef struct packed {
		logic clr;
		logic vld;
		logic last;
	} mac_ctl_t;

endpackage

`default_nettype wire

FILE: sv/smm_req_if.sv
// Request channel: valid/ready plus one load or query transaction.
// Depends on smm_pkg.
`default_nettype none

interface smm_req_if import smm_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic [IDX_W-1:0]         row_index;
	logic [IDX_W-1:0]         col_index;
	logic signed [ELEM_W-1:0] element_value;

	modport source (output valid, action, row_index, col_index, element_value, input ready);
	modport sink   (input valid, action, row_index, col_index, element_value, output ready);
endinterface

`default_nettype wire

FILE: sv/smm_rsp_if.sv
// Response channel: valid/ready plus one product element transaction.
// Depends on smm_pkg.
`default_nettype none

interface smm_rsp_if import smm_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [ACC_W-1:0] product_value;
	logic [IDX_W-1:0]        out_row;
	logic [IDX_W-1:0]        out_col;
	logic                    index_error;

	modport source (output valid, product_value, out_row, out_col, index_error, input ready);
	modport sink   (input valid, product_value, out_row, out_col, index_error, output ready);
endinterface

`default_nettype wire

FILE: sv/smm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module smm_ram #(
	parameter int DATA_W = 16,
	parameter int ADDR_W = 8
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: sv/smm_mac.sv
// Two-stage multiply-accumulate: registered product, then 40-bit accumulate.
// Depends on smm_pkg.
`default_nettype none

module smm_mac import smm_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mac_ctl_t                 ctl,
	input  wire logic signed [ELEM_W-1:0] a,
	input  wire logic signed [ELEM_W-1:0] b,
	output logic signed      [ACC_W-1:0]  acc,
	output logic                          done
);

	logic                     vld_s1, last_s1;
	logic                     vld_s2, last_s2;
	logic                     done_q;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	// s1 lines up with the RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1  <= ctl.vld;
			last_s1 <= ctl.vld & ctl.last;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
			done_q  <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

`default_nettype wire

FILE: sv/square_matrix_multiply_core.sv
// Square matrix multiply core: top level with sequencer, A/B stores and MAC.
// Depends on smm_pkg, smm_req_if, smm_rsp_if, smm_ram, smm_mac.
`default_nettype none

// Computes single elements of C = A x B for square matrices of dimension
// n = min(size_in_use, 16). Each request transaction either loads one 16-bit
// signed element of A or B at (row, col), or queries C[row][col]. A load gives
// no response; loads at or beyond n are dropped. A query walks k = 0..n-1
// reading A[row][k] and B[k][col] from two one-port-read RAMs, one pair per
// cycle, into one multiply-accumulate unit, so a query occupies the request
// side through accept, the n reads, the drain of the RAM and MAC stages and
// the hand-off to the response register; that MAC loop sets the throughput. A
// query with row or col at or beyond n answers with index_error set and
// product_value 0. Sums are exact in 40 bits. Reading an element never loaded
// since reset returns an unspecified value. The response register lets a new
// request be accepted while the previous response waits. size_in_use is
// written through cfg_we/cfg_wdata and must only change while the core is
// idle.
module square_matrix_multiply_core import smm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [SIZE_W-1:0] cfg_wdata,
	smm_req_if.sink                req,
	smm_rsp_if.source              rsp
);

	state_t state_q, state_d;

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] n_eff;
	logic              req_inside;
	logic              accept;
	logic              is_query;

	logic [IDX_W-1:0] k_q;
	logic             k_last;
	logic [IDX_W-1:0] row_q, col_q;
	logic             err_q;

	// sequencer outputs
	logic     req_ready;
	logic     wr_a, wr_b;
	logic     rsp_load;
	mac_ctl_t mac_ctl;

	logic              out_free;
	logic [ELEM_W-1:0] a_rdata, b_rdata;
	logic signed [ACC_W-1:0] acc;
	logic              mac_done;

	logic                    rsp_valid_q;
	logic signed [ACC_W-1:0] rsp_value_q;
	logic [IDX_W-1:0]        rsp_row_q, rsp_col_q;
	logic                    rsp_err_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	// sizes above the store dimension clamp to it
	assign n_eff = (size_q > SIZE_MAX) ? SIZE_MAX : size_q;

	assign req_inside = ({1'b0, req.row_index} < n_eff) && ({1'b0, req.col_index} < n_eff);
	assign accept     = req.valid & req_ready;
	assign is_query   = (req.action == ACT_QUERY);
	assign k_last     = ({1'b0, k_q} == (n_eff - SIZE_W'(1)));
	assign out_free   = !rsp_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && is_query) begin
					state_d = req_inside ? S_RUN : S_DONE;
				end
			end
			S_RUN: begin
				if (k_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (mac_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_ready    = 1'b0;
		wr_a         = 1'b0;
		wr_b         = 1'b0;
		rsp_load     = 1'b0;
		mac_ctl      = '0;
		unique case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				wr_a        = req.valid && (req.action == ACT_LOAD_A) && req_inside;
				wr_b        = req.valid && (req.action == ACT_LOAD_B) && req_inside;
				mac_ctl.clr = req.valid && is_query && req_inside;
			end
			S_RUN: begin
				mac_ctl.vld  = 1'b1;
				mac_ctl.last = k_last;
			end
			S_DRAIN: begin
			end
			S_DONE: begin
				rsp_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_RUN) begin
				k_q <= k_q + IDX_W'(1);
			end else begin
				k_q <= '0;
			end
		end
	end

	// query transaction held for the whole walk
	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			row_q <= req.row_index;
			col_q <= req.col_index;
			err_q <= !req_inside;
		end
	end

	// A is read along its row, B down its column; the request side is closed
	// during the walk, so no load can hit an entry in flight
	smm_ram #(
		.DATA_W (ELEM_W),
		.ADDR_W (ADDR_W)
	) u_a_ram (
		.clk   (clk),
		.we    (wr_a),
		.waddr ({req.row_index, req.col_index}),
		.wdata (req.element_value),
		.raddr ({row_q, k_q}),
		.rdata (a_rdata)
	);

	smm_ram #(
		.DATA_W (ELEM_W),
		.ADDR_W (ADDR_W)
	) u_b_ram (
		.clk   (clk),
		.we    (wr_b),
		.waddr ({req.row_index, req.col_index}),
		.wdata (req.element_value),
		.raddr ({k_q, col_q}),
		.rdata (b_rdata)
	);

	smm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (a_rdata),
		.b      (b_rdata),
		.acc    (acc),
		.done   (mac_done)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_value_q <= err_q ? '0 : acc;
			rsp_row_q   <= row_q;
			rsp_col_q   <= col_q;
			rsp_err_q   <= err_q;
		end
	end

	assign req.ready         = req_ready;
	assign rsp.valid         = rsp_valid_q;
	assign rsp.product_value = rsp_value_q;
	assign rsp.out_row       = rsp_row_q;
	assign rsp.out_col       = rsp_col_q;
	assign rsp.index_error   = rsp_err_q;

	// MAC completion only ever arrives while draining
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == S_DRAIN))
		else $error("MAC done outside drain");

	// walk index never reaches the dimension in use
	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> ({1'b0, k_q} < n_eff))
		else $error("k out of range during walk");

	// error responses carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.index_error) |-> (rsp.product_value == '0))
		else $error("index error with nonzero value");

	// response loads only when the register is free or being drained
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> (!rsp_valid_q || rsp.ready))
		else $error("response overwritten");

endmodule

`default_nettype wire

FILE: tb/square_matrix_multiply_core_test.sv
// Self-checking testbench for square_matrix_multiply_core: loads A and B, queries C elements.
// Depends on smm_pkg, smm_req_if, smm_rsp_if and the core RTL.
`default_nettype none

module square_matrix_multiply_core_test;
	import smm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Action 3 has no name in the package; the core must ignore it.
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	// Settling wait once the last response has arrived, long enough to cover
	// anything still in flight.
	localparam int DRAIN_CYCLES  = 32;
	// Long response back-pressure, used once to fill the core and stall requests.
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_PHASE    = 6;
	// Cycles with no transaction on either channel before the run is declared hung.
	localparam int STUCK_LIMIT   = 4000;
	localparam int RAND_PHASES   = 12;
	localparam int ITEMS_PER_PH  = 100;
	localparam int PRINT_CAP     = 100;

	typedef logic signed [ELEM_W-1:0] elem_t;

	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [ELEM_W-1:0] elem;
	} request_t;

	typedef struct packed {
		logic [ACC_W-1:0] value;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             err;
	} product_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;

	smm_req_if req_ch();
	smm_rsp_if rsp_ch();

	square_matrix_multiply_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Matrix model: our own copy of A, B and the dimension register.
	// ------------------------------------------------------------------
	elem_t             left_elems  [MAX_SIZE*MAX_SIZE];
	elem_t             right_elems [MAX_SIZE*MAX_SIZE];
	logic [SIZE_W-1:0] size_reg;

	request_t request_queue[$];      // transactions waiting for the driver
	product_t expected_products[$];  // predicted responses, oldest first
	request_t on_offer;              // transaction currently on the request channel
	product_t want;

	int  send_idle_pct;
	int  recv_idle_pct;
	logic rsp_hold;
	int  failures;
	int  stuck_cycles;

	// Sizes above MAX_SIZE clamp; zero leaves every index out of range.
	function automatic int unsigned active_dim();
		return (size_reg > MAX_SIZE) ? MAX_SIZE : size_reg;
	endfunction

	// Exact 40-bit sum over k of A[row][k] * B[k][col].
	function automatic logic [ACC_W-1:0] dot_product(int unsigned row, int unsigned col,
			int unsigned n);
		logic signed [ACC_W-1:0]  sum;
		logic signed [PROD_W-1:0] term;
		sum = '0;
		for (int unsigned k = 0; k < n; k++) begin
			term = left_elems[row*MAX_SIZE + k] * right_elems[k*MAX_SIZE + col];
			sum += term;
		end
		return sum;
	endfunction

	// Apply one accepted request transaction to the model.
	function automatic void take_request(request_t r);
		int unsigned n;
		bit          fits;
		product_t    p;
		n = active_dim();
		fits = (r.row < n) && (r.col < n);
		case (r.act)
			ACT_LOAD_A: begin
				if (fits)
					left_elems[r.row*MAX_SIZE + r.col] = r.elem;
			end
			ACT_LOAD_B: begin
				if (fits)
					right_elems[r.row*MAX_SIZE + r.col] = r.elem;
			end
			ACT_QUERY: begin
				p.value = fits ? dot_product(r.row, r.col, n) : '0;
				p.row   = r.row;
				p.col   = r.col;
				p.err   = !fits;
				expected_products.push_back(p);
			end
			default: ;
		endcase
	endfunction

	task automatic note_failure(input string msg);
		if (failures < PRINT_CAP)
			$display("mismatch at %0t: %s", $time, msg);
		failures++;
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic void queue_request(logic [ACT_W-1:0] a, int unsigned r,
			int unsigned c, elem_t e);
		request_t t;
		t.act  = a;
		t.row  = IDX_W'(r);
		t.col  = IDX_W'(c);
		t.elem = e;
		request_queue.push_back(t);
	endfunction

	// Element values lean on the extremes so large sums show up often.
	function automatic elem_t random_element();
		case ($urandom_range(7))
			0:       return elem_t'(16'h8000);
			1:       return elem_t'(16'h7FFF);
			2:       return '0;
			default: return elem_t'($urandom);
		endcase
	endfunction

	// An index inside [0, n) or outside it; falls back when one side is empty.
	function automatic int unsigned pick_index(int unsigned n, bit want_inside);
		if (n == 0)
			return $urandom_range(MAX_SIZE - 1);
		if (want_inside || n >= MAX_SIZE)
			return $urandom_range(n - 1);
		return $urandom_range(MAX_SIZE - 1, n);
	endfunction

	// Mostly well-formed loads and queries; some out-of-range ones and action 3.
	function automatic request_t random_request(int unsigned n);
		request_t    r;
		int unsigned pick;
		bit          bad_row;
		pick = $urandom_range(99);
		r.elem = random_element();
		r.row  = IDX_W'(pick_index(n, 1'b1));
		r.col  = IDX_W'(pick_index(n, 1'b1));
		if (pick < 36) begin
			r.act = ACT_LOAD_A;
		end else if (pick < 62) begin
			r.act = ACT_LOAD_B;
		end else if (pick < 90) begin
			r.act = ACT_QUERY;
		end else if (pick < 94) begin
			r.act = ACT_UNUSED;
			r.row = IDX_W'($urandom);
			r.col = IDX_W'($urandom);
		end else begin
			// one index pushed past the dimension
			case ($urandom_range(2))
				0:       r.act = ACT_LOAD_A;
				1:       r.act = ACT_LOAD_B;
				default: r.act = ACT_QUERY;
			endcase
			bad_row = 1'($urandom_range(1));
			if (bad_row)
				r.row = IDX_W'(pick_index(n, 1'b0));
			else
				r.col = IDX_W'(pick_index(n, 1'b0));
		end
		return r;
	endfunction

	// Small dimensions most of the time; now and then zero, full or oversize.
	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(9))
			0:       return '0;
			1:       return SIZE_W'($urandom_range(31, MAX_SIZE + 1));
			2:       return SIZE_W'(MAX_SIZE);
			3:       return SIZE_W'(1);
			default: return SIZE_W'($urandom_range(8, 2));
		endcase
	endfunction

	// Hold until every queued request went out and every response came back,
	// then let the core finish anything that gives no response.
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (request_queue.size() != 0 || req_ch.valid || expected_products.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Dimension writes happen only with the core idle.
	task automatic set_dimension(input logic [SIZE_W-1:0] v);
		wait_quiet();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		size_reg  = v;
	endtask

	// ------------------------------------------------------------------
	// Request driver: presents queued transactions, holds each until accepted,
	// and feeds the model at the edge where the transaction is taken.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				take_request(on_offer);
			if (!req_ch.valid || req_ch.ready) begin
				if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_offer = request_queue.pop_front();
					req_ch.valid         <= 1'b1;
					req_ch.action        <= on_offer.act;
					req_ch.row_index     <= on_offer.row;
					req_ch.col_index     <= on_offer.col;
					req_ch.element_value <= on_offer.elem;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response side: random ready, forced low during the long hold.
	always @(posedge clk) begin
		rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	// Response monitor: every accepted transaction against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_products.size() == 0) begin
				note_failure($sformatf("unexpected response row %0d col %0d",
					rsp_ch.out_row, rsp_ch.out_col));
			end else begin
				want = expected_products.pop_front();
				if (rsp_ch.product_value !== want.value)
					note_failure($sformatf("C[%0d][%0d] product %0d, want %0d",
						want.row, want.col, rsp_ch.product_value, $signed(want.value)));
				if (rsp_ch.out_row !== want.row)
					note_failure($sformatf("out_row %0d, want %0d", rsp_ch.out_row, want.row));
				if (rsp_ch.out_col !== want.col)
					note_failure($sformatf("out_col %0d, want %0d", rsp_ch.out_col, want.col));
				if (rsp_ch.index_error !== want.err)
					note_failure($sformatf("C[%0d][%0d] index_error %b, want %b",
						want.row, want.col, rsp_ch.index_error, want.err));
			end
		end
	end

	// Watchdog: a long run of cycles with no transaction means the core hung.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
			$display("** square_matrix_multiply_core: FAILED **");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned dim;
		int unsigned counted;
		request_t    r;

		// every input known from time zero
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		req_ch.valid         = 1'b0;
		req_ch.action        = ACT_LOAD_A;
		req_ch.row_index     = '0;
		req_ch.col_index     = '0;
		req_ch.element_value = '0;
		rsp_ch.ready         = 1'b0;
		rsp_hold             = 1'b0;
		failures             = 0;
		stuck_cycles         = 0;
		size_reg             = SIZE_RESET;
		send_idle_pct        = 33;
		recv_idle_pct        = 84;
		foreach (left_elems[i]) begin
			left_elems[i]  = '0;
			right_elems[i] = '0;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Write every entry of A and B once so no query ever reads an unwritten
		// element. Row 15 and row 14 of A and column 15 of B carry the extremes
		// for the largest positive and negative sums below.
		for (int i = 0; i < MAX_SIZE; i++)
			for (int j = 0; j < MAX_SIZE; j++)
				queue_request(ACT_LOAD_A, i, j, (i == 15) ? elem_t'(16'h8000) :
					(i == 14) ? elem_t'(16'h7FFF) : random_element());
		for (int i = 0; i < MAX_SIZE; i++)
			for (int j = 0; j < MAX_SIZE; j++)
				queue_request(ACT_LOAD_B, i, j,
					(j == 15) ? elem_t'(16'h8000) : random_element());

		// Full size: largest positive and negative sums, corners, action 3.
		queue_request(ACT_QUERY, 15, 15, '0);
		queue_request(ACT_QUERY, 14, 15, elem_t'(16'h7FFF));
		queue_request(ACT_QUERY, 0, 0, '0);
		queue_request(ACT_QUERY, 0, 15, '0);
		queue_request(ACT_QUERY, 15, 0, '0);
		queue_request(ACT_UNUSED, 15, 15, elem_t'(16'h7FFF));
		queue_request(ACT_LOAD_A, 0, 0, elem_t'(16'h8000));
		queue_request(ACT_QUERY, 0, 0, '0);

		// Size 1: loads and queries past the edge, one valid product.
		set_dimension(SIZE_W'(1));
		queue_request(ACT_LOAD_A, 1, 0, elem_t'(16'h1234));
		queue_request(ACT_LOAD_B, 0, 1, elem_t'(16'h4321));
		queue_request(ACT_QUERY, 1, 0, '0);
		queue_request(ACT_QUERY, 0, 1, '0);
		queue_request(ACT_QUERY, 15, 15, '0);
		queue_request(ACT_LOAD_A, 0, 0, elem_t'(16'h7FFF));
		queue_request(ACT_LOAD_B, 0, 0, elem_t'(16'h8000));
		queue_request(ACT_QUERY, 0, 0, '0);

		// Size zero: nothing is in range.
		set_dimension('0);
		queue_request(ACT_LOAD_A, 0, 0, elem_t'(16'h0001));
		queue_request(ACT_QUERY, 0, 0, '0);
		queue_request(ACT_QUERY, 15, 15, '0);

		// Oversize register value clamps to the full matrix.
		set_dimension(SIZE_W'(31));
		queue_request(ACT_QUERY, 15, 15, '0);
		queue_request(ACT_QUERY, 3, 7, '0);

		// Random phases, each at its own dimension. Idling: sender light and
		// receiver heavy first, then swapped, then both flat out.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == RAND_PHASES / 3) begin
				send_idle_pct = 84;
				recv_idle_pct = 33;
			end else if (ph == 2 * RAND_PHASES / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_dimension((ph == HOLD_PHASE) ? SIZE_W'(4) : pick_size());
			dim = active_dim();

			// Back-pressure phase: the receiver refuses everything while the
			// sender keeps offering, so the core fills and drops its ready.
			if (ph == HOLD_PHASE)
				rsp_hold <= 1'b1;

			// every transaction counts, ignored ones included
			counted = 0;
			while (counted < ITEMS_PER_PH) begin
				r = random_request(dim);
				request_queue.push_back(r);
				counted++;
			end

			if (ph == HOLD_PHASE) begin
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_hold <= 1'b0;
			end
		end

		wait_quiet();
		if (failures == 0)
			$display("** square_matrix_multiply_core: PASSED **");
		else
			$display("** square_matrix_multiply_core: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
